FILE: sv/fsv_pkg.sv
// Package for the FASTA stream validator: result kinds, error codes,
// line phase codes and the result word type. No dependencies.
package fsv_pkg;

  typedef enum logic [2:0] {
    K_NAME    = 3'd0,
    K_BASE    = 3'd1,
    K_REC_END = 3'd2,
    K_DONE    = 3'd3,
    K_ERROR   = 3'd4
  } out_kind_e;

  typedef enum logic [2:0] {
    E_EMPTY_LINE = 3'd0,
    E_NO_HEADER  = 3'd1,
    E_EMPTY_NAME = 3'd2,
    E_EMPTY_SEQ  = 3'd3,
    E_BAD_BASE   = 3'd4
  } err_code_e;

  // Line phase, one-hot.
  typedef enum logic [2:0] {
    PH_START  = 3'b001,
    PH_HEADER = 3'b010,
    PH_SEQ    = 3'b100
  } phase_e;

  typedef struct packed {
    out_kind_e   kind;
    logic [7:0]  ch;
    logic [31:0] len;
    err_code_e   err;
    logic        ok;
    logic        last;
  } result_t;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;

endpackage

FILE: sv/fsv_out_fifo.sv
// Result queue for the FASTA stream validator: takes up to two result words
// per cycle and hands one word per cycle to the output while it is ready. Depends on fsv_pkg.
module fsv_out_fifo
  import fsv_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  output logic       room2_o,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output result_t    pop_data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t        mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_p1;
  logic [CW-1:0]  count_q, count_d;
  logic           pop;

  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign room2_o     = (count_q <= CW'(DEPTH - 2));
  assign wr_ptr_p1   = wr_ptr_q + PW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_n_i);
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + CW'(push_n_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_p1] <= push1_i;
    end
  end

endmodule

FILE: sv/fasta_stream_validator.sv
// FASTA stream validator: one byte word in per cycle while the queue has room
// for two results; results go out through a four-word queue (fsv_out_fifo),
// which registers them. An end word yields up to two results, both buffered
// by the queue.
// Reset is asynchronous, active low, and clears all parser state and the queue.
module fasta_stream_validator
  import fsv_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value[7:0]
  input  logic        s_axis_tuser,   // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // char_value[7:0], record_length[39:8],
                                      // error_code[42:40], file_ok[43], zero[47:44]
  output logic [2:0]  m_axis_tuser,   // out_kind[2:0]
  output logic        m_axis_tlast    // last_result
);

  localparam int LW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  phase_e                phase_q, phase_d;
  logic                  rec_open_q, rec_open_d;
  logic                  name_ne_q, name_ne_d;
  logic                  failed_q, failed_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [LW-1:0]         cnt_ext;
  logic [31:0]           len32;
  logic                  in_acc;
  logic [7:0]            b, up;
  logic                  is_base;
  logic [1:0]            n;
  result_t               r0, r1, head;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign b       = s_axis_tdata;
  assign up      = (b >= CH_LA && b <= CH_LZ) ? b - 8'd32 : b;
  assign is_base = (up == CH_A) || (up == CH_C) || (up == CH_G) ||
                   (up == CH_T) || (up == CH_N);
  assign cnt_inc = (cnt_q != '1) ? cnt_q + COUNT_BITS'(1) : cnt_q;
  assign cnt_ext = LW'(cnt_q);
  assign len32   = (cnt_ext > LW'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cnt_ext[31:0];

  always_comb begin
    phase_d    = phase_q;
    rec_open_d = rec_open_q;
    name_ne_d  = name_ne_q;
    failed_d   = failed_q;
    cnt_d      = cnt_q;
    n          = 2'd0;
    r0         = '{kind: K_NAME, ch: 8'd0, len: 32'd0, err: E_EMPTY_LINE,
                   ok: 1'b0, last: 1'b0};
    r1         = r0;
    if (s_axis_tuser) begin
      r1.kind = K_DONE;
      if (!failed_q) begin
        n       = 2'd2;
        r0.kind = K_ERROR;
        r1.ok   = 1'b1;
        if (!rec_open_q) begin
          r0.err = E_NO_HEADER;
          r1.ok  = 1'b0;
        end else if (phase_q == PH_HEADER && !name_ne_q) begin
          r0.err = E_EMPTY_NAME;
          r1.ok  = 1'b0;
        end else if (cnt_q == '0) begin
          r0.err = E_EMPTY_SEQ;
          r1.ok  = 1'b0;
        end else begin
          r0.kind = K_REC_END;
          r0.len  = len32;
        end
      end else begin
        n  = 2'd1;
        r0 = r1;
      end
      phase_d    = PH_START;
      rec_open_d = 1'b0;
      name_ne_d  = 1'b0;
      failed_d   = 1'b0;
      cnt_d      = '0;
    end else if (!failed_q) begin
      n       = 2'd1;
      r0.kind = K_ERROR;
      case (phase_q)
        PH_HEADER: begin
          if (b == CH_LF) begin
            if (!name_ne_q) begin
              r0.err = E_EMPTY_NAME;
            end else begin
              n       = 2'd0;
              phase_d = PH_START;
            end
          end else begin
            name_ne_d = 1'b1;
            r0.kind   = K_NAME;
            r0.ch     = b;
          end
        end
        PH_SEQ: begin
          if (b == CH_LF) begin
            n       = 2'd0;
            phase_d = PH_START;
          end else if (!is_base) begin
            r0.err = E_BAD_BASE;
          end else begin
            r0.kind = K_BASE;
            r0.ch   = up;
            cnt_d   = cnt_inc;
          end
        end
        default: begin
          if (b == CH_LF) begin
            r0.err = E_EMPTY_LINE;
          end else if (b == CH_GT) begin
            if (rec_open_q && cnt_q == '0) begin
              r0.err = E_EMPTY_SEQ;
            end else begin
              // A header closes the open record, if there is one.
              if (rec_open_q) begin
                r0.kind = K_REC_END;
                r0.len  = len32;
              end else begin
                n = 2'd0;
              end
              rec_open_d = 1'b1;
              name_ne_d  = 1'b0;
              cnt_d      = '0;
              phase_d    = PH_HEADER;
            end
          end else if (!rec_open_q) begin
            r0.err = E_NO_HEADER;
          end else if (!is_base) begin
            r0.err  = E_BAD_BASE;
            phase_d = PH_SEQ;
          end else begin
            r0.kind = K_BASE;
            r0.ch   = up;
            cnt_d   = cnt_inc;
            phase_d = PH_SEQ;
          end
        end
      endcase
      if (n != 2'd0 && r0.kind == K_ERROR) begin
        failed_d = 1'b1;
      end
    end
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      rec_open_q <= 1'b0;
      name_ne_q  <= 1'b0;
      failed_q   <= 1'b0;
      cnt_q      <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      rec_open_q <= rec_open_d;
      name_ne_q  <= name_ne_d;
      failed_q   <= failed_d;
      cnt_q      <= cnt_d;
    end
  end

  fsv_out_fifo #(
    .DEPTH(4)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (in_acc ? n : 2'd0),
    .push0_i    (r0),
    .push1_i    (r1),
    .room2_o    (s_axis_tready),
    .pop_valid_o(m_axis_tvalid),
    .pop_ready_i(m_axis_tready),
    .pop_data_o (head)
  );

  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {4'd0, head.ok, head.err, head.len, head.ch};

`ifndef NO_ASSERTIONS
  a_end_gives_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser) |=> m_axis_tvalid)
    else $error("end word accepted but no result queued");

  a_end_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser) |=> (!failed_q && !rec_open_q && cnt_q == '0))
    else $error("end word did not re-arm the parser");

  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (failed_q && !(in_acc && s_axis_tuser)) |=> failed_q)
    else $error("error state cleared without an end word");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == K_DONE) |-> m_axis_tlast)
    else $error("done word not marked last");
`endif

endmodule
